FILE: design/sqs_pkg.sv
package sqs_pkg;

	localparam int CAP_W      = 7;
	localparam int FUNC_W     = 3;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int POS_W      = 6;
	localparam int ENTRIES_W  = 7;
	localparam int SCAN_CHUNK = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [FUNC_W-1:0] FN_ENQ    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DEQ    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] read_value;
		logic [POS_W-1:0]          found_position;
		logic [ENTRIES_W-1:0]      entries_held;
		logic                      is_empty;
		logic                      is_full;
	} rsp_t;

	typedef struct packed {
		logic busy;
		logic hit;
		logic last;
	} scan_st_t;

endpackage

FILE: design/sqs_cell.sv
module sqs_cell #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 load,
	input  logic                 shift,
	input  logic [WORD_BITS-1:0] load_word,
	input  logic [WORD_BITS-1:0] next_word,
	input  logic [WORD_BITS-1:0] key,
	input  logic                 live,
	output logic [WORD_BITS-1:0] word,
	output logic                 match
);
	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end else if (shift) begin
			word_q <= next_word;
		end
	end

	assign word  = word_q;
	assign match = live && (word_q == key);

endmodule

FILE: design/sqs_scan.sv
module sqs_scan #(
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [DEPTH-1:0]                        match,
	input  logic [$clog2(DEPTH+1)-1:0]              count,
	input  logic                                    finish,
	output sqs_pkg::scan_st_t                       st,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pos
);
	import sqs_pkg::*;

	localparam int CW  = $clog2(DEPTH+1);
	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NCH = (DEPTH + SCAN_CHUNK - 1) / SCAN_CHUNK;
	localparam int VW  = NCH * SCAN_CHUNK;
	localparam int BW  = $clog2(VW+1);
	localparam int SW  = ((BW > CW) ? BW : CW) + 1;
	localparam int EW  = $clog2(SCAN_CHUNK);

	logic [VW-1:0] vec_q;
	logic [BW-1:0] base_q;
	logic          busy_q;
	logic [EW-1:0] enc;
	logic          hit;
	logic          last;

	// lowest set bit of the chunk at the head of the vector
	always_comb begin
		enc = '0;
		for (int j = SCAN_CHUNK-1; j >= 0; j--) begin
			if (vec_q[j]) enc = EW'(j);
		end
	end

	assign hit  = |vec_q[SCAN_CHUNK-1:0];
	assign last = (SW'(base_q) + SW'(SCAN_CHUNK)) >= SW'(count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (hit || last) && finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q  <= VW'(match);
			base_q <= '0;
		end else if (busy_q && !hit && !last) begin
			// advance one chunk toward the head
			vec_q  <= vec_q >> SCAN_CHUNK;
			base_q <= base_q + BW'(SCAN_CHUNK);
		end
	end

	assign st.busy = busy_q;
	assign st.hit  = hit;
	assign st.last = last;
	assign pos     = PW'(base_q + BW'(enc));

endmodule

FILE: design/shifting_queue_with_search.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we (no wait)       cfg_wdata: capacity
// req       in         req_valid / req_ready  req: func, value
// rsp       out        rsp_valid / rsp_ready  rsp: status, read_value, found_position,
//                                             entries_held, is_empty, is_full
//
// For enqueue, dequeue, peek, clear and unused codes the cells load or shift in
// parallel and the result goes straight to the response register.
// For search the cells compare in parallel and the match vector is registered, then
// walked eight positions a cycle from the head until a hit or the last chunk.
// Reset clears the count, the capacity (to 64) and the response register; no clearing pass.
// A stalled response holds the next request back; one request is in flight at a time.
module shifting_queue_with_search #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sqs_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  sqs_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output sqs_pkg::rsp_t             rsp
);
	import sqs_pkg::*;

	localparam int CW   = $clog2(DEPTH+1);
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t               state_q;
	logic [CAP_W-1:0]     cap_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nxt;
	rsp_t                 rsp_q;
	rsp_t                 rsp_nxt;
	logic                 rsp_valid_q;
	logic                 rsp_free;
	logic                 accept;
	logic                 full_now;
	logic                 enq_ok;
	logic                 deq_ok;
	logic                 scan_start;
	logic                 scan_finish;
	scan_st_t             scan_st;
	logic [PW-1:0]        scan_pos;
	logic [WORD_BITS-1:0] key;
	logic [WORD_BITS-1:0] words [DEPTH];
	logic [DEPTH-1:0]     match;

	function automatic logic full_of(input logic [CW-1:0] cnt, input logic [CAP_W-1:0] cap);
		return (cnt == CW'(DEPTH)) || (CMPW'(cnt) >= CMPW'(cap));
	endfunction

	assign key       = WORD_BITS'($unsigned(req.value));
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && rsp_free;
	assign accept    = req_valid && req_ready;
	assign full_now  = full_of(count_q, cap_q);
	assign enq_ok    = accept && (req.func == FN_ENQ) && !full_now;
	assign deq_ok    = accept && (req.func == FN_DEQ) && (count_q != '0);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] next_word;
		if (i == DEPTH-1) begin : g_tail
			assign next_word = words[i];
		end else begin : g_mid
			assign next_word = words[i+1];
		end
		sqs_cell #(.WORD_BITS(WORD_BITS)) u_cell (
			.clk      (clk),
			.load     (enq_ok && (count_q == CW'(i))),
			.shift    (deq_ok),
			.load_word(key),
			.next_word(next_word),
			.key      (key),
			.live     (count_q > CW'(i)),
			.word     (words[i]),
			.match    (match[i])
		);
	end

	assign scan_start  = accept && (req.func == FN_SEARCH);
	assign scan_finish = (state_q == S_SCAN) && scan_st.busy &&
		(scan_st.hit || scan_st.last) && rsp_free;

	sqs_scan #(.DEPTH(DEPTH)) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.match (match),
		.count (count_q),
		.finish(scan_finish),
		.st    (scan_st),
		.pos   (scan_pos)
	);

	always_comb begin
		count_nxt              = count_q;
		rsp_nxt                = '0;
		rsp_nxt.status         = ST_OK;
		case (req.func)
			FN_ENQ: begin
				if (full_now) rsp_nxt.status = ST_FULL;
				else count_nxt = count_q + CW'(1);
			end
			FN_DEQ: begin
				if (count_q == '0) begin
					rsp_nxt.status = ST_EMPTY;
				end else begin
					rsp_nxt.read_value = VALUE_W'(words[0]);
					count_nxt          = count_q - CW'(1);
				end
			end
			FN_PEEK: begin
				if (count_q == '0) rsp_nxt.status = ST_EMPTY;
				else rsp_nxt.read_value = VALUE_W'(words[0]);
			end
			FN_CLEAR: count_nxt = '0;
			default: ;
		endcase
		rsp_nxt.entries_held = ENTRIES_W'(count_nxt);
		rsp_nxt.is_empty     = (count_nxt == '0);
		rsp_nxt.is_full      = full_of(count_nxt, cap_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req.func != FN_SEARCH)) begin
						count_q     <= count_nxt;
						rsp_q       <= rsp_nxt;
						rsp_valid_q <= 1'b1;
					end else begin
						if (accept) state_q <= S_SCAN;
						if (rsp_ready) rsp_valid_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (scan_finish) begin
						rsp_q.status         <= scan_st.hit ? ST_OK : ST_MISS;
						rsp_q.read_value     <= '0;
						rsp_q.found_position <= scan_st.hit ? POS_W'(scan_pos) : '0;
						rsp_q.entries_held   <= ENTRIES_W'(count_q);
						rsp_q.is_empty       <= (count_q == '0);
						rsp_q.is_full        <= full_now;
						rsp_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end else if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: tb/shifting_queue_with_search_tb.sv
`timescale 1ns / 100ps

module shifting_queue_with_search_tb;
	import sqs_pkg::*;

	localparam int DEPTH        = 64;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int LIMIT_CYCLES = 500000;
	localparam int MAX_REPORTS  = 150;

	// func codes with no operation behind them
	localparam logic [FUNC_W-1:0] FN_NOP5 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_NOP6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_NOP7 = 3'd7;

	typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [FUNC_W-1:0] func;
		logic [31:0]       value;
		bit                typed;
		rsp_t              want;
	} dir_row_t;

	localparam int DIR_ROWS = 29;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;

	shifting_queue_with_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// shadow copy of the queue
	logic signed [VALUE_W-1:0] held_words [DEPTH];
	int unsigned               held_count;
	logic [CAP_W-1:0]          capacity_reg;

	rsp_t rsp_backlog [$];
	bit   quiet;
	int   cycle_count;
	int   n_fail;
	int   n_req;
	int   n_rsp;
	int   n_hits;
	int   n_refused;
	int   n_settings;
	int   peak_count;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{ROW_REQ, FN_PEEK,   32'h0,        1'b1, '{ST_EMPTY, 32'sh0, 6'd0, 7'd0, 1'b1, 1'b0}},
		'{ROW_REQ, FN_DEQ,    32'h0,        1'b1, '{ST_EMPTY, 32'sh0, 6'd0, 7'd0, 1'b1, 1'b0}},
		'{ROW_REQ, FN_SEARCH, 32'h0,        1'b1, '{ST_MISS,  32'sh0, 6'd0, 7'd0, 1'b1, 1'b0}},
		'{ROW_REQ, FN_ENQ,    32'h7fffffff, 1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd1, 1'b0, 1'b0}},
		'{ROW_REQ, FN_ENQ,    32'h80000000, 1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd2, 1'b0, 1'b0}},
		'{ROW_REQ, FN_ENQ,    32'h7fffffff, 1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_SEARCH, 32'h80000000, 1'b1, '{ST_OK,    32'sh0, 6'd1, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_SEARCH, 32'h7fffffff, 1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_SEARCH, 32'h0,        1'b1, '{ST_MISS,  32'sh0, 6'd0, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_PEEK,   32'h0,        1'b1,
			'{ST_OK, 32'sh7fffffff, 6'd0, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_NOP5,   32'hffffffff, 1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_NOP6,   32'h0,        1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_NOP7,   32'h12345678, 1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd3, 1'b0, 1'b0}},
		'{ROW_REQ, FN_DEQ,    32'h0,        1'b1,
			'{ST_OK, 32'sh7fffffff, 6'd0, 7'd2, 1'b0, 1'b0}},
		// drop the capacity below the count: entries stay, queue reads full
		'{ROW_CAP, FN_ENQ,    32'd1,        1'b0, '0},
		'{ROW_REQ, FN_ENQ,    32'h1,        1'b1, '{ST_FULL,  32'sh0, 6'd0, 7'd2, 1'b0, 1'b1}},
		'{ROW_REQ, FN_DEQ,    32'h0,        1'b1,
			'{ST_OK, 32'sh80000000, 6'd0, 7'd1, 1'b0, 1'b1}},
		'{ROW_REQ, FN_DEQ,    32'h0,        1'b1,
			'{ST_OK, 32'sh7fffffff, 6'd0, 7'd0, 1'b1, 1'b0}},
		'{ROW_REQ, FN_ENQ,    32'hffffffff, 1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd1, 1'b0, 1'b1}},
		'{ROW_REQ, FN_CLEAR,  32'h0,        1'b1, '{ST_OK,    32'sh0, 6'd0, 7'd0, 1'b1, 1'b0}},
		// cleared words must not match
		'{ROW_REQ, FN_SEARCH, 32'hffffffff, 1'b1, '{ST_MISS,  32'sh0, 6'd0, 7'd0, 1'b1, 1'b0}},
		// zero capacity: always full
		'{ROW_CAP, FN_ENQ,    32'd0,        1'b0, '0},
		'{ROW_REQ, FN_ENQ,    32'h5,        1'b1, '{ST_FULL,  32'sh0, 6'd0, 7'd0, 1'b1, 1'b1}},
		// capacity above depth saturates
		'{ROW_CAP, FN_ENQ,    32'd127,      1'b0, '0},
		'{ROW_REQ, FN_ENQ,    32'h0,        1'b0, '0},
		'{ROW_REQ, FN_ENQ,    32'h5a5a5a5a, 1'b0, '0},
		'{ROW_REQ, FN_SEARCH, 32'h5a5a5a5a, 1'b0, '0},
		'{ROW_REQ, FN_DEQ,    32'h0,        1'b0, '0},
		'{ROW_CAP, FN_ENQ,    32'd64,       1'b0, '0}
	};

	function automatic rsp_t apply_queue_op(input req_t r);
		rsp_t        o;
		int unsigned limit;
		int          i;
		bit          hit;
		o = '0;
		hit = 1'b0;
		limit = (32'(capacity_reg) > DEPTH) ? DEPTH : 32'(capacity_reg);
		case (r.func)
			FN_ENQ: begin
				if (held_count >= limit) begin
					o.status = ST_FULL;
					n_refused++;
				end else begin
					held_words[IDX_W'(held_count)] = r.value;
					held_count++;
				end
			end
			FN_DEQ: begin
				if (held_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.read_value = held_words[0];
					for (i = 0; i + 1 < held_count; i++)
						held_words[IDX_W'(i)] = held_words[IDX_W'(i + 1)];
					held_count--;
				end
			end
			FN_PEEK: begin
				if (held_count == 0)
					o.status = ST_EMPTY;
				else
					o.read_value = held_words[0];
			end
			FN_CLEAR: held_count = 0;
			FN_SEARCH: begin
				o.status = ST_MISS;
				for (i = 0; i < held_count; i++) begin
					if (!hit && held_words[IDX_W'(i)] == r.value) begin
						hit = 1'b1;
						o.status = ST_OK;
						o.found_position = i[POS_W-1:0];
					end
				end
				if (hit)
					n_hits++;
			end
			default: ;
		endcase
		if (held_count > peak_count)
			peak_count = held_count;
		o.entries_held = held_count[ENTRIES_W-1:0];
		o.is_empty = (held_count == 0);
		o.is_full = (held_count >= limit);
		return o;
	endfunction

	function automatic logic [31:0] draw_word();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 32'($urandom_range(0, 7)) - 32'd4;
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h0;
					default: return 32'hffffffff;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// drive one request and hold it until taken, then maybe idle
	task automatic send_req(input req_t r, input bit typed, input rsp_t want);
		rsp_t pred;
		int   gap;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pred = apply_queue_op(r);
		rsp_backlog.push_back(typed ? want : pred);
		n_req++;
		@(negedge clk);
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_rsp(input int settle);
		req_valid <= 1'b0;
		while (rsp_backlog.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] c);
		drain_rsp(12);
		cfg_wdata <= c;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		capacity_reg = c;
		n_settings++;
	endtask

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("shifting_queue_with_search test failed");
			$finish;
		end
	end

	// response side: random stalls, compare against the oldest prediction
	initial begin
		rsp_t want;
		int   stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = quiet ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			n_rsp++;
			if (rsp_backlog.size() == 0) begin
				n_fail++;
				$error("response with no request outstanding");
			end else begin
				want = rsp_backlog.pop_front();
				if (want != rsp) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS) begin
						if (want.status != rsp.status)
							$error("status: expected %0d, got %0d", want.status, rsp.status);
						if (want.read_value != rsp.read_value)
							$error("read_value: expected %0d, got %0d",
								want.read_value, rsp.read_value);
						if (want.found_position != rsp.found_position)
							$error("found_position: expected %0d, got %0d",
								want.found_position, rsp.found_position);
						if (want.entries_held != rsp.entries_held)
							$error("entries_held: expected %0d, got %0d",
								want.entries_held, rsp.entries_held);
						if (want.is_empty != rsp.is_empty)
							$error("is_empty: expected %0d, got %0d",
								want.is_empty, rsp.is_empty);
						if (want.is_full != rsp.is_full)
							$error("is_full: expected %0d, got %0d",
								want.is_full, rsp.is_full);
					end
				end
			end
		end
	end

	initial begin
		req_t             item;
		logic [CAP_W-1:0] cap;
		int               enq_pct;
		int               pick;
		int               ph;
		int               k;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		quiet = 1'b0;
		cycle_count = 0;
		n_fail = 0;
		n_req = 0;
		n_rsp = 0;
		n_hits = 0;
		n_refused = 0;
		n_settings = 0;
		peak_count = 0;
		held_count = 0;
		capacity_reg = CAP_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			if (directed_rows[k].kind == ROW_CAP) begin
				set_capacity(directed_rows[k].value[CAP_W-1:0]);
			end else begin
				item.func = directed_rows[k].func;
				item.value = directed_rows[k].value;
				send_req(item, directed_rows[k].typed, directed_rows[k].want);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0, 5, 7: cap = 7'd64;
				1: cap = 7'd127;
				2: cap = 7'($urandom_range(2, 8));
				3: cap = 7'd1;
				4: cap = 7'($urandom_range(9, 63));
				default: cap = 7'($urandom_range(0, 127));
			endcase
			set_capacity(cap);
			enq_pct = (ph == 0 || ph == 5) ? 75 : 45 + 15 * (ph % 3);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				item.value = draw_word();
				if ($urandom_range(0, 99) < enq_pct) begin
					item.func = FN_ENQ;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 40) begin
						item.func = FN_DEQ;
					end else if (pick < 55) begin
						item.func = FN_PEEK;
					end else if (pick < 93) begin
						item.func = FN_SEARCH;
						// half the time, look for a word that is held
						if (held_count > 0 && $urandom_range(0, 1) == 1)
							item.value =
								held_words[IDX_W'($urandom_range(0, held_count - 1))];
					end else if (pick < 97) begin
						item.func = FN_CLEAR;
					end else begin
						case ($urandom_range(0, 2))
							0: item.func = FN_NOP5;
							1: item.func = FN_NOP6;
							default: item.func = FN_NOP7;
						endcase
					end
				end
				send_req(item, 1'b0, '0);
			end
		end

		quiet = 1'b0;
		drain_rsp(20);
		$display("covered %0d requests, %0d responses over %0d capacity settings",
			n_req, n_rsp, n_settings);
		$display("peak occupancy %0d, %0d search hits, %0d refused enqueues",
			peak_count, n_hits, n_refused);
		if (n_fail == 0)
			$display("shifting_queue_with_search test passed");
		else
			$display("shifting_queue_with_search test failed");
		$finish;
	end

endmodule

FILE: shifting_queue_with_search.f
design/sqs_pkg.sv
design/sqs_cell.sv
design/sqs_scan.sv
design/shifting_queue_with_search.sv
tb/shifting_queue_with_search_tb.sv
